[rtl/core/assert_macros.svh]
// Assertion macros shared by the dispatcher RTL.
// Depends on nothing; the including module must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TPJD_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define TPJD_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/tpjd_pkg.sv]
// Types, codes and defaults for the typed priority job dispatcher.
// Depends on nothing; used by tpjd_pick, the top level, the checker and the testbench.
package tpjd_pkg;

  localparam int JOB_SLOTS_DEF    = 64;
  localparam int WORKERS_DEF      = 8;
  localparam int FINISH_DEPTH_DEF = 64;

  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 32;
  localparam int PLIM_W  = 7;
  localparam int AWORK_W = 4;

  localparam logic [CFG_IW-1:0] CFG_PENDING_LIMIT  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ACTIVE_WORKERS = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_WORKER_TYPES   = 2'd2;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_QWORKER = 2'd1,
    CMD_QJOB    = 2'd2,
    CMD_QLIST   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    JST_PENDING   = 2'd0,
    JST_DOING     = 2'd1,
    JST_DONE      = 2'd2,
    JST_DISCARDED = 2'd3
  } jst_t;

  typedef enum logic [1:0] {
    PICK_MAX   = 2'd0,
    PICK_MIN   = 2'd1,
    PICK_FIRST = 2'd2
  } pick_mode_t;

  typedef enum logic [1:0] {
    SCAN_TAKE  = 2'd0,
    SCAN_EVICT = 2'd1,
    SCAN_FIND  = 2'd2
  } scan_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_TICK_RD,
    S_SCAN,
    S_CMD,
    S_INSERT,
    S_QW_RD,
    S_LIST_RD,
    S_LIST_LD,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic       clear;
    logic       valid;
    pick_mode_t mode;
  } pick_ctl_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pri;
    logic [15:0] need;
    logic [3:0]  kind;
  } job_static_t;

  typedef struct packed {
    jst_t        st;
    logic [15:0] el;
  } job_dyn_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  job_status;
    logic        worker_busy;
    logic [15:0] current_job;
    logic [15:0] finished_job;
    logic        last;
    logic        list_empty;
    logic        accepted;
    logic        evicted;
    logic [15:0] evicted_job;
    logic        list_overflow;
  } out_t;

endpackage

[rtl/core/tpjd_if.sv]
// Valid/ready channel interfaces for command items and result items.
// Depends on nothing.
interface tpjd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] job_id;
  logic [15:0] job_priority;
  logic [15:0] job_need;
  logic [3:0]  job_kind;
  logic [2:0]  worker_slot;

  modport source (output valid, command, job_id, job_priority, job_need, job_kind,
                  worker_slot, input ready);
  modport sink (input valid, command, job_id, job_priority, job_need, job_kind,
                worker_slot, output ready);
endinterface

interface tpjd_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  job_status;
  logic        worker_busy;
  logic [15:0] current_job;
  logic [15:0] finished_job;
  logic        last;
  logic        list_empty;
  logic        accepted;
  logic        evicted;
  logic [15:0] evicted_job;
  logic        list_overflow;

  modport source (output valid, found, job_status, worker_busy, current_job,
                  finished_job, last, list_empty, accepted, evicted, evicted_job,
                  list_overflow, input ready);
  modport sink (input valid, found, job_status, worker_busy, current_job,
                finished_job, last, list_empty, accepted, evicted, evicted_job,
                list_overflow, output ready);
endinterface

[rtl/core/tpjd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tpjd_ram #(
  parameter int W = 16,
  parameter int D = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                     wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                     rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/tpjd_pick.sv]
// Shared select unit: keeps the best candidate of a table scan and counts candidates.
// Depends on tpjd_pkg.
module tpjd_pick #(
  parameter int IW = 6,
  parameter int CW = 7,
  parameter int PW = 34
) (
  input  logic                clk,
  input  logic                rst,
  input  tpjd_pkg::pick_ctl_t ctl,
  input  logic                cand,
  input  logic [15:0]         pri,
  input  logic [IW-1:0]       idx,
  input  logic [PW-1:0]       payload,
  output logic                have,
  output logic [IW-1:0]       best_idx,
  output logic [PW-1:0]       best_payload,
  output logic [CW-1:0]       cnt
);
  import tpjd_pkg::*;

  logic [15:0] best_pri;
  logic        better;

  always_comb begin
    unique case (ctl.mode)
      PICK_MAX: better = pri > best_pri;
      PICK_MIN: better = pri < best_pri;
      default:  better = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      have <= 1'b0;
      cnt  <= '0;
    end else if (ctl.valid && cand) begin
      cnt <= cnt + CW'(1);
      if (!have || better) begin
        have         <= 1'b1;
        best_pri     <= pri;
        best_idx     <= idx;
        best_payload <= payload;
      end
    end
  end
endmodule

[rtl/core/typed_priority_job_dispatcher.sv]
// Top level of the typed priority job dispatcher: sequencer, worker registers, job tables.
// Depends on tpjd_pkg, tpjd_if, tpjd_ram, tpjd_pick and assert_macros.svh.
//
//   channel   dir   handshake        carries
//   in_ch     in    valid/ready      command, job fields, worker_slot
//   out_ch    out   valid/ready      one result item (several for a list query)
//   cfg_*     in    cfg_we           register index and write data
//
// Sequence: one command at a time: accept in idle, then for each active worker a job
// table read that advances its job, or a table scan that picks a job when the worker is
// idle or its job is done; then leave the tick loop and decode the command. An add runs
// an evict scan and an insert, a job query a scan, a worker query one read, a list query
// a read and a load per id; every result item is then held until out_ch.ready is high.
// The single select unit walking the job table RAM port paces every scan.
// Reset: synchronous; clears workers, finished counts and job_count. Table RAMs are
// not cleared: job_count bounds every read, so no clearing pass is needed.
// Stalls: in_ch.ready is high only in idle; a stalled result holds the sequencer.
`include "assert_macros.svh"

module typed_priority_job_dispatcher #(
  parameter int JOB_SLOTS    = tpjd_pkg::JOB_SLOTS_DEF,
  parameter int WORKERS      = tpjd_pkg::WORKERS_DEF,
  parameter int FINISH_DEPTH = tpjd_pkg::FINISH_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  tpjd_in_if.sink                     in_ch,
  tpjd_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [tpjd_pkg::CFG_IW-1:0] cfg_index,
  input  logic [tpjd_pkg::CFG_DW-1:0] cfg_data
);
  import tpjd_pkg::*;

  localparam int SLOT_W = $clog2(JOB_SLOTS);
  localparam int CNT_W  = $clog2(JOB_SLOTS + 1);
  localparam int WIX    = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int FIN_CW = $clog2(FINISH_DEPTH + 1);
  localparam int FIN_D  = WORKERS * FINISH_DEPTH;
  localparam int FA_W   = (FIN_D > 1) ? $clog2(FIN_D) : 1;
  localparam int LIM_W  = (CNT_W > PLIM_W) ? CNT_W : PLIM_W;
  localparam int ST_W   = $bits(job_static_t);
  localparam int DY_W   = $bits(job_dyn_t);
  localparam int PW     = 16 + DY_W;

  // Configuration registers
  logic [PLIM_W-1:0]  pending_limit;
  logic [AWORK_W-1:0] active_workers;
  logic [31:0]        worker_types;

  // Sequencer and latched command
  seq_state_t state, state_next;
  cmd_t        q_cmd;
  logic [15:0] q_id, q_pri, q_need;
  logic [3:0]  q_kind;
  logic [2:0]  q_ws;

  // Worker state
  logic              has_job  [WORKERS];
  logic [SLOT_W-1:0] job_slot [WORKERS];
  logic [FIN_CW-1:0] fin_cnt  [WORKERS];
  logic              fin_ovf  [WORKERS];
  logic [3:0]        w;
  logic [WIX-1:0]    wi, wsi;

  logic [CNT_W-1:0]  job_count;
  logic [CNT_W-1:0]  scan_idx;
  logic              rd_vld;
  logic [SLOT_W-1:0] rd_idx;
  scan_kind_t        scan_kind, scan_kind_next;
  logic              scan_start;
  logic [FIN_CW-1:0] li;
  out_t              out_q;

  // RAM ports
  logic [SLOT_W-1:0] jaddr, dy_waddr;
  logic              st_we, dy_we, fin_we;
  job_static_t       st_rd, st_wdata;
  job_dyn_t          dy_rd, dy_wdata;
  logic [FA_W-1:0]   fin_waddr, fin_raddr;
  logic [15:0]       fin_rd;

  // Select unit
  pick_ctl_t         pctl;
  logic              cand, p_have;
  logic [SLOT_W-1:0] p_idx;
  logic [PW-1:0]     p_payload;
  logic [CNT_W-1:0]  p_cnt;
  logic [15:0]       best_id;
  job_dyn_t          best_dyn;

  // Decode helpers
  logic        tick_on, slot_stale, issue, scan_done, ws_ok, evict_now, room;
  logic [15:0] el_inc;
  logic        job_done, fin_room;
  logic [3:0]  wkind;
  logic        list_none;

  assign wi        = w[WIX-1:0];
  assign wsi       = q_ws[WIX-1:0];
  assign wkind     = worker_types[{w[2:0], 2'b00} +: 4];
  assign tick_on   = (w < active_workers) && (int'(w) < WORKERS);
  assign slot_stale = CNT_W'(job_slot[wi]) >= job_count;
  assign issue     = scan_idx < job_count;
  assign scan_done = !issue && !rd_vld;
  assign ws_ok     = int'(q_ws) < WORKERS;
  assign evict_now = p_have && (LIM_W'(p_cnt) >= LIM_W'(pending_limit));
  assign room      = job_count < CNT_W'(JOB_SLOTS);
  assign el_inc    = dy_rd.el + 16'd1;
  assign job_done  = el_inc == st_rd.need;
  assign fin_room  = fin_cnt[wi] < FIN_CW'(FINISH_DEPTH);
  assign best_id   = p_payload[PW-1 -: 16];
  assign best_dyn  = job_dyn_t'(p_payload[DY_W-1:0]);
  // list query with nothing to list: answer with one empty item
  assign list_none = (q_cmd == CMD_QLIST) && (!ws_ok || fin_cnt[wsi] == '0);

  assign fin_waddr = FA_W'(int'(wi) * FINISH_DEPTH + int'(fin_cnt[wi]));
  assign fin_raddr = FA_W'(int'(wsi) * FINISH_DEPTH + int'(li));

  assign st_wdata = '{id: q_id, pri: q_pri, need: q_need, kind: q_kind};

  // Candidate test for the running scan
  always_comb begin
    unique case (scan_kind)
      SCAN_TAKE:  cand = (st_rd.kind == wkind) && (dy_rd.st == JST_PENDING);
      SCAN_EVICT: cand = dy_rd.st == JST_PENDING;
      SCAN_FIND:  cand = st_rd.id == q_id;
      default:    cand = 1'b0;
    endcase
    pctl.clear = scan_start;
    pctl.valid = rd_vld && (state == S_SCAN);
    unique case (scan_kind)
      SCAN_TAKE:  pctl.mode = PICK_MAX;
      SCAN_EVICT: pctl.mode = PICK_MIN;
      default:    pctl.mode = PICK_FIRST;
    endcase
  end

  // Next state and RAM control
  always_comb begin
    state_next     = state;
    jaddr          = scan_idx[SLOT_W-1:0];
    st_we          = 1'b0;
    dy_we          = 1'b0;
    dy_waddr       = job_slot[wi];
    dy_wdata       = dy_rd;
    fin_we         = 1'b0;
    scan_start     = 1'b0;
    scan_kind_next = SCAN_TAKE;
    in_ch.ready    = 1'b0;
    out_ch.valid   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) state_next = S_TICK;
      end
      S_TICK: begin
        if (!tick_on) begin
          state_next = S_CMD;
        end else if (has_job[wi] && !slot_stale) begin
          jaddr      = job_slot[wi];
          state_next = S_TICK_RD;
        end else begin
          // idle worker, or one whose job left the table: pick a new job
          scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_TICK_RD: begin
        dy_we    = 1'b1;
        dy_wdata = '{st: job_done ? JST_DONE : dy_rd.st, el: el_inc};
        fin_we   = job_done && fin_room;
        if (job_done) begin
          scan_start = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_TICK;
        end
      end
      S_SCAN: begin
        scan_kind_next = scan_kind;
        if (scan_done) begin
          unique case (scan_kind)
            SCAN_TAKE: begin
              dy_we      = p_have;
              dy_waddr   = p_idx;
              dy_wdata   = '{st: JST_DOING, el: best_dyn.el};
              state_next = S_TICK;
            end
            SCAN_EVICT: begin
              dy_we      = evict_now;
              dy_waddr   = p_idx;
              dy_wdata   = '{st: JST_DISCARDED, el: best_dyn.el};
              state_next = S_INSERT;
            end
            default: state_next = S_OUT;
          endcase
        end
      end
      S_CMD: begin
        unique case (q_cmd)
          CMD_ADD: begin
            scan_start     = 1'b1;
            scan_kind_next = SCAN_EVICT;
            state_next     = S_SCAN;
          end
          CMD_QWORKER: begin
            jaddr = job_slot[wsi];
            if (ws_ok && has_job[wsi] && CNT_W'(job_slot[wsi]) < job_count) begin
              state_next = S_QW_RD;
            end else begin
              state_next = S_OUT;
            end
          end
          CMD_QJOB: begin
            scan_start     = 1'b1;
            scan_kind_next = SCAN_FIND;
            state_next     = S_SCAN;
          end
          CMD_QLIST: begin
            if (list_none) state_next = S_OUT;
            else           state_next = S_LIST_RD;
          end
          default: state_next = S_OUT;
        endcase
      end
      S_INSERT: begin
        jaddr      = job_count[SLOT_W-1:0];
        st_we      = room;
        dy_we      = room;
        dy_waddr   = job_count[SLOT_W-1:0];
        dy_wdata   = '{st: JST_PENDING, el: 16'd0};
        state_next = S_OUT;
      end
      S_QW_RD:   state_next = S_OUT;
      S_LIST_RD: state_next = S_LIST_LD;
      S_LIST_LD: state_next = S_OUT;
      S_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          if (q_cmd == CMD_QLIST && !out_q.last) state_next = S_LIST_RD;
          else                                  state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Datapath and worker registers
  always_ff @(posedge clk) begin
    if (rst) begin
      w         <= '0;
      job_count <= '0;
      rd_vld    <= 1'b0;
      scan_idx  <= '0;
      scan_kind <= SCAN_TAKE;
      for (int k = 0; k < WORKERS; k++) begin
        has_job[k]  <= 1'b0;
        job_slot[k] <= '0;
        fin_cnt[k]  <= '0;
        fin_ovf[k]  <= 1'b0;
      end
    end else begin
      if (scan_start) begin
        scan_idx  <= '0;
        scan_kind <= scan_kind_next;
        rd_vld    <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            q_cmd  <= cmd_t'(in_ch.command);
            q_id   <= in_ch.job_id;
            q_pri  <= in_ch.job_priority;
            q_need <= in_ch.job_need;
            q_kind <= in_ch.job_kind;
            q_ws   <= in_ch.worker_slot;
            w      <= '0;
          end
        end
        S_TICK: begin
          if (tick_on && has_job[wi] && slot_stale) has_job[wi] <= 1'b0;
        end
        S_TICK_RD: begin
          if (job_done) begin
            if (fin_room) fin_cnt[wi] <= fin_cnt[wi] + FIN_CW'(1);
            else          fin_ovf[wi] <= 1'b1;
          end else begin
            w <= w + 4'd1;
          end
        end
        S_SCAN: begin
          // issue the next table read; the select unit sees its data in the next cycle
          if (issue) begin
            scan_idx <= scan_idx + CNT_W'(1);
            rd_vld   <= 1'b1;
            rd_idx   <= scan_idx[SLOT_W-1:0];
          end else begin
            rd_vld <= 1'b0;
          end
          if (scan_done) begin
            unique case (scan_kind)
              SCAN_TAKE: begin
                has_job[wi] <= p_have;
                if (p_have) job_slot[wi] <= p_idx;
                w <= w + 4'd1;
              end
              SCAN_EVICT: begin
                if (evict_now) begin
                  out_q.evicted     <= 1'b1;
                  out_q.evicted_job <= best_id;
                end
              end
              default: begin
                out_q.found      <= p_have;
                out_q.job_status <= p_have ? best_dyn.st : JST_PENDING;
              end
            endcase
          end
        end
        S_CMD: begin
          out_q <= '{last: 1'b1, list_empty: list_none,
                     list_overflow: list_none && ws_ok && fin_ovf[wsi], default: '0};
          li    <= '0;
        end
        S_INSERT: begin
          if (room) begin
            job_count      <= job_count + CNT_W'(1);
            out_q.accepted <= 1'b1;
          end
        end
        S_QW_RD: begin
          out_q.worker_busy <= 1'b1;
          out_q.current_job <= st_rd.id;
        end
        S_LIST_LD: begin
          out_q.finished_job  <= fin_rd;
          out_q.last          <= (li + FIN_CW'(1)) == fin_cnt[wsi];
          out_q.list_overflow <= fin_ovf[wsi];
        end
        S_OUT: begin
          if (out_ch.ready && q_cmd == CMD_QLIST && !out_q.last) li <= li + FIN_CW'(1);
        end
        default: ;
      endcase
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_limit  <= PLIM_W'(64);
      active_workers <= AWORK_W'(1);
      worker_types   <= '0;
    end else if (cfg_we) begin
      priority case (cfg_index)
        CFG_PENDING_LIMIT:  pending_limit  <= cfg_data[PLIM_W-1:0];
        CFG_ACTIVE_WORKERS: active_workers <= cfg_data[AWORK_W-1:0];
        CFG_WORKER_TYPES:   worker_types   <= cfg_data;
        default: ;
      endcase
    end
  end

  tpjd_ram #(.W(ST_W), .D(JOB_SLOTS)) u_static (
    .clk(clk), .we(st_we), .waddr(job_count[SLOT_W-1:0]), .wdata(st_wdata),
    .raddr(jaddr), .rdata(st_rd)
  );

  tpjd_ram #(.W(DY_W), .D(JOB_SLOTS)) u_dyn (
    .clk(clk), .we(dy_we), .waddr(dy_waddr), .wdata(dy_wdata),
    .raddr(jaddr), .rdata(dy_rd)
  );

  tpjd_ram #(.W(16), .D(FIN_D)) u_fin (
    .clk(clk), .we(fin_we), .waddr(fin_waddr), .wdata(st_rd.id),
    .raddr(fin_raddr), .rdata(fin_rd)
  );

  tpjd_pick #(.IW(SLOT_W), .CW(CNT_W), .PW(PW)) u_pick (
    .clk(clk), .rst(rst), .ctl(pctl), .cand(cand), .pri(st_rd.pri), .idx(rd_idx),
    .payload({st_rd.id, dy_rd}), .have(p_have), .best_idx(p_idx),
    .best_payload(p_payload), .cnt(p_cnt)
  );

  assign out_ch.found         = out_q.found;
  assign out_ch.job_status    = out_q.job_status;
  assign out_ch.worker_busy   = out_q.worker_busy;
  assign out_ch.current_job   = out_q.current_job;
  assign out_ch.finished_job  = out_q.finished_job;
  assign out_ch.last          = out_q.last;
  assign out_ch.list_empty    = out_q.list_empty;
  assign out_ch.accepted      = out_q.accepted;
  assign out_ch.evicted       = out_q.evicted;
  assign out_ch.evicted_job   = out_q.evicted_job;
  assign out_ch.list_overflow = out_q.list_overflow;

  `TPJD_CHECK(a_ready_no_result, in_ch.ready |-> !out_ch.valid, "input taken while a result waits")
  `TPJD_CHECK(a_count_bound, job_count <= CNT_W'(JOB_SLOTS), "job count beyond table size")
  `TPJD_CHECK(a_add_single, out_ch.valid && out_ch.accepted |-> out_ch.last, "add gave several results")
  `TPJD_CHECK_NEXT(a_insert_grows, state == S_INSERT && room, job_count == $past(job_count) + CNT_W'(1), "insert did not grow table")
endmodule

[sim/tpjd_checker.sv]
// Checker for the dispatcher: watches the command, result and register channels,
// predicts results and compares them. Depends on tpjd_pkg and tpjd_if from the RTL.
`timescale 1ns / 1ps

module tpjd_checker
  import tpjd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  tpjd_in_if                  in_ch,
  tpjd_out_if                 out_ch,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data,
  output int                  fail_count,
  output int                  outstanding
);
  localparam int NSLOT = JOB_SLOTS_DEF;
  localparam int NWORK = WORKERS_DEF;
  localparam int NFIN  = FINISH_DEPTH_DEF;

  logic [PLIM_W-1:0]  lim;
  logic [AWORK_W-1:0] nact;
  logic [31:0]        wkinds;

  logic [15:0] tab_id[NSLOT], tab_pri[NSLOT], tab_need[NSLOT], tab_el[NSLOT];
  logic [3:0]  tab_kind[NSLOT];
  jst_t        tab_st[NSLOT];
  int          tab_n;
  bit          wk_busy[NWORK];
  int          wk_slot[NWORK];
  logic [15:0] done_ids[NWORK][NFIN];
  int          done_n[NWORK];
  bit          done_ovf[NWORK];

  out_t results_due[$];

  assign outstanding = results_due.size();

  task automatic report(string what, int got, int want);
    $display("%0t: result %s got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void grab_job(int w);
    logic [3:0] k;
    bit have;
    int best;
    k = wkinds[4*w +: 4];
    have = 0;
    best = 0;
    for (int i = 0; i < tab_n; i++)
      if (tab_kind[i] == k && tab_st[i] == JST_PENDING)
        if (!have || tab_pri[i] > tab_pri[best]) begin
          best = i;
          have = 1;
        end
    wk_busy[w] = have;
    if (have) begin
      wk_slot[w] = best;
      tab_st[best] = JST_DOING;
    end
  endfunction

  function automatic void advance_worker(int w);
    int s;
    if (!wk_busy[w]) begin
      grab_job(w);
      return;
    end
    s = wk_slot[w];
    if (s >= tab_n) begin
      wk_busy[w] = 0;
      grab_job(w);
      return;
    end
    tab_el[s] = tab_el[s] + 16'd1;
    if (tab_el[s] == tab_need[s]) begin
      tab_st[s] = JST_DONE;
      if (done_n[w] < NFIN) begin
        done_ids[w][done_n[w]] = tab_id[s];
        done_n[w]++;
      end else
        done_ovf[w] = 1;
      grab_job(w);
    end
  endfunction

  // Work out every result of one command and queue them.
  function automatic void dispatch_command(cmd_t c, logic [15:0] id, logic [15:0] pri,
                                           logic [15:0] need, logic [3:0] kind,
                                           logic [2:0] ws);
    out_t r;
    int nw, pend, low;
    bit have;
    nw = (nact < NWORK) ? nact : NWORK;
    for (int w = 0; w < nw; w++) advance_worker(w);
    r = '0;
    r.last = 1;
    case (c)
      CMD_ADD: begin
        pend = 0;
        have = 0;
        low = 0;
        for (int i = 0; i < tab_n; i++)
          if (tab_st[i] == JST_PENDING) begin
            pend++;
            if (!have || tab_pri[i] < tab_pri[low]) begin
              low = i;
              have = 1;
            end
          end
        if (have && pend >= lim) begin
          tab_st[low] = JST_DISCARDED;
          r.evicted = 1;
          r.evicted_job = tab_id[low];
        end
        if (tab_n < NSLOT) begin
          tab_id[tab_n] = id;
          tab_pri[tab_n] = pri;
          tab_need[tab_n] = need;
          tab_kind[tab_n] = kind;
          tab_el[tab_n] = '0;
          tab_st[tab_n] = JST_PENDING;
          tab_n++;
          r.accepted = 1;
        end
        results_due.push_back(r);
      end
      CMD_QWORKER: begin
        if (wk_busy[ws] && wk_slot[ws] < tab_n) begin
          r.worker_busy = 1;
          r.current_job = tab_id[wk_slot[ws]];
        end
        results_due.push_back(r);
      end
      CMD_QJOB: begin
        for (int i = 0; i < tab_n; i++)
          if (tab_id[i] == id) begin
            r.found = 1;
            r.job_status = tab_st[i];
            break;
          end
        results_due.push_back(r);
      end
      default: begin
        r.list_overflow = done_ovf[ws];
        if (done_n[ws] == 0) begin
          r.list_empty = 1;
          results_due.push_back(r);
        end else
          for (int i = 0; i < done_n[ws]; i++) begin
            r.finished_job = done_ids[ws][i];
            r.last = (i + 1 == done_n[ws]);
            results_due.push_back(r);
          end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      lim = 7'd64;
      nact = 4'd1;
      wkinds = '0;
      tab_n = 0;
      for (int w = 0; w < NWORK; w++) begin
        wk_busy[w] = 0;
        wk_slot[w] = 0;
        done_n[w] = 0;
        done_ovf[w] = 0;
      end
      results_due.delete();
    end else begin
      if (cfg_we)
        case (cfg_index)
          CFG_PENDING_LIMIT:  lim = cfg_data[PLIM_W-1:0];
          CFG_ACTIVE_WORKERS: nact = cfg_data[AWORK_W-1:0];
          CFG_WORKER_TYPES:   wkinds = cfg_data;
          default: ;
        endcase
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0)
          report("unexpected", 1, 0);
        else begin
          out_t e;
          e = results_due.pop_front();
          if (out_ch.found !== e.found) report("found", out_ch.found, e.found);
          if (out_ch.job_status !== e.job_status)
            report("job_status", out_ch.job_status, e.job_status);
          if (out_ch.worker_busy !== e.worker_busy)
            report("worker_busy", out_ch.worker_busy, e.worker_busy);
          if (out_ch.current_job !== e.current_job)
            report("current_job", out_ch.current_job, e.current_job);
          if (out_ch.finished_job !== e.finished_job)
            report("finished_job", out_ch.finished_job, e.finished_job);
          if (out_ch.last !== e.last) report("last", out_ch.last, e.last);
          if (out_ch.list_empty !== e.list_empty)
            report("list_empty", out_ch.list_empty, e.list_empty);
          if (out_ch.accepted !== e.accepted)
            report("accepted", out_ch.accepted, e.accepted);
          if (out_ch.evicted !== e.evicted) report("evicted", out_ch.evicted, e.evicted);
          if (out_ch.evicted_job !== e.evicted_job)
            report("evicted_job", out_ch.evicted_job, e.evicted_job);
          if (out_ch.list_overflow !== e.list_overflow)
            report("list_overflow", out_ch.list_overflow, e.list_overflow);
        end
      end
      if (in_ch.valid && in_ch.ready)
        dispatch_command(cmd_t'(in_ch.command), in_ch.job_id, in_ch.job_priority,
                         in_ch.job_need, in_ch.job_kind, in_ch.worker_slot);
    end
  end

  initial fail_count = 0;

  final if (results_due.size() != 0) ;
endmodule

[sim/tb_top.sv]
// Top of the dispatcher testbench: clock, reset, command stimulus, register writes
// and result back-pressure. Depends on tpjd_pkg, tpjd_if, the block and tpjd_checker.
`timescale 1ns / 1ps

module tb_top;
  import tpjd_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  int fail_count, outstanding;

  tpjd_in_if  in_ch();
  tpjd_out_if out_ch();

  // Sender and receiver idling, in percent; long_hold asks for one long stall.
  int send_idle = 0;
  int recv_stall = 0;
  bit long_hold = 0;
  logic [15:0] used_ids[$];

  // Per-phase register settings and idling.
  int lims[6] = '{64, 1, 3, 8, 2, 64};
  int acts[6] = '{8, 0, 4, 15, 8, 3};
  int idles[6] = '{0, 56, 0, 11, 0, 56};
  int stalls[6] = '{0, 0, 56, 11, 0, 56};

  typed_priority_job_dispatcher dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tpjd_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.command = '0;
    in_ch.job_id = '0;
    in_ch.job_priority = '0;
    in_ch.job_need = '0;
    in_ch.job_kind = '0;
    in_ch.worker_slot = '0;
    out_ch.ready = 0;
  end

  // Receiver: hold ready low for a long counted stretch when asked, else stall at random.
  always @(posedge clk) begin
    int hold_left;
    if (long_hold && hold_left == 0) begin
      hold_left = 3000;
      long_hold <= 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 0;
    end else
      out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // Offer one item and hold it until the block takes it; then maybe idle a little.
  task automatic send_item(cmd_t c, logic [15:0] id, logic [15:0] pri,
                           logic [15:0] need, logic [3:0] kind, logic [2:0] ws);
    in_ch.valid <= 1;
    in_ch.command <= c;
    in_ch.job_id <= id;
    in_ch.job_priority <= pri;
    in_ch.job_need <= need;
    in_ch.job_kind <= kind;
    in_ch.worker_slot <= ws;
    if (c == CMD_ADD) used_ids.push_back(id);
    do @(posedge clk); while (!in_ch.ready);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every result has come back.
  task automatic drain();
    in_ch.valid <= 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Random command: adds use small needs and few kinds so jobs finish and compete.
  task automatic random_item();
    cmd_t c;
    logic [15:0] id, need;
    logic [3:0] kind;
    int pick;
    pick = $urandom_range(99);
    c = (pick < 16) ? CMD_ADD : (pick < 45) ? CMD_QWORKER :
        (pick < 75) ? CMD_QJOB : CMD_QLIST;
    id = 16'($urandom);
    if (c == CMD_QJOB && used_ids.size() > 0 && $urandom_range(3) != 0)
      id = used_ids[$urandom_range(used_ids.size() - 1)];
    else if (c == CMD_ADD && used_ids.size() > 0 && $urandom_range(9) == 0)
      id = used_ids[$urandom_range(used_ids.size() - 1)];
    need = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
    kind = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
    send_item(c, id, 16'($urandom), need, kind, 3'($urandom));
  endtask

  function automatic logic [31:0] random_kinds();
    logic [31:0] v;
    for (int w = 0; w < 8; w++) v[4*w +: 4] = 4'($urandom_range(0, 3));
    return v;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty queries, field extremes, eviction, duplicates and zero need.
    write_reg(CFG_PENDING_LIMIT, 2);
    write_reg(CFG_ACTIVE_WORKERS, 2);
    write_reg(CFG_WORKER_TYPES, 32'h0000_00F0);
    send_item(CMD_QLIST, 16'h0, 16'h0, 16'h1, 4'h0, 3'd0);
    send_item(CMD_QWORKER, 16'h0, 16'h0, 16'h1, 4'h0, 3'd7);
    send_item(CMD_QJOB, 16'hFFFF, 16'h0, 16'h1, 4'h0, 3'd0);
    send_item(CMD_ADD, 16'h0000, 16'h0000, 16'h0001, 4'h0, 3'd0);
    send_item(CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 3'd7);
    send_item(CMD_ADD, 16'h0101, 16'h0005, 16'h0002, 4'h3, 3'd0);
    send_item(CMD_ADD, 16'h0102, 16'h0005, 16'h0002, 4'h3, 3'd0);
    send_item(CMD_ADD, 16'h0103, 16'h0009, 16'h0000, 4'h3, 3'd0);
    send_item(CMD_ADD, 16'h0101, 16'h0007, 16'h0001, 4'h0, 3'd0);
    send_item(CMD_ADD, 16'h0201, 16'h0003, 16'h0001, 4'h0, 3'd0);
    send_item(CMD_QJOB, 16'h0101, 16'h0, 16'h1, 4'h0, 3'd0);
    send_item(CMD_QJOB, 16'h0000, 16'h0, 16'h1, 4'h0, 3'd0);
    send_item(CMD_QJOB, 16'hFFFF, 16'h0, 16'h1, 4'h0, 3'd0);
    send_item(CMD_QWORKER, 16'h0, 16'h0, 16'h1, 4'h0, 3'd0);
    send_item(CMD_QWORKER, 16'h0, 16'h0, 16'h1, 4'h0, 3'd1);
    send_item(CMD_QLIST, 16'h0, 16'h0, 16'h1, 4'h0, 3'd0);
    send_item(CMD_QLIST, 16'h0, 16'h0, 16'h1, 4'h0, 3'd1);
    send_item(CMD_QLIST, 16'h0, 16'h0, 16'h1, 4'h0, 3'd7);
    send_item(CMD_QJOB, 16'h0201, 16'h0, 16'h1, 4'h0, 3'd0);
    drain();

    // Random phases, each with its own register setting and idling.
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_PENDING_LIMIT, lims[p]);
      write_reg(CFG_ACTIVE_WORKERS, acts[p]);
      write_reg(CFG_WORKER_TYPES, (p == 3) ? 32'hFFFF_FFFF : random_kinds());
      send_idle = idles[p];
      recv_stall = stalls[p];
      if (p == 4) long_hold = 1;
      repeat (72) random_item();
      // pause mid-phase until everything is back, then carry on
      if (p == 1) drain();
      repeat (3) random_item();
      drain();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/tpjd_pkg.sv
rtl/core/tpjd_if.sv
rtl/core/tpjd_ram.sv
rtl/core/tpjd_pick.sv
rtl/core/typed_priority_job_dispatcher.sv
sim/tpjd_checker.sv
sim/tb_top.sv
